[rtl/assert_macros.svh]
// shared assertion macros, sampled on clk, off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[rtl/plc_pkg.sv]
package plc_pkg;

  localparam int COORD_FRAC_BITS = 4;
  localparam int COORD_INT_BITS  = 16;
  localparam int CW        = COORD_INT_BITS + COORD_FRAC_BITS;
  localparam int MW        = CW + 1;
  localparam int PW        = 2 * CW;
  localparam int DIV_STEPS = PW;
  localparam int FW        = PW + 2;
  localparam int XW        = PW + 4;
  localparam int LATENCY   = DIV_STEPS + 7;

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_CENTER  = 3'd0;
  localparam mode_t MODE_FILL    = 3'd1;
  localparam mode_t MODE_MARGIN  = 3'd2;
  localparam mode_t MODE_FIT     = 3'd3;
  localparam mode_t MODE_FIT_TOP = 3'd4;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_MODE    = 3'd0;
  localparam reg_idx_t REG_MLEFT   = 3'd1;
  localparam reg_idx_t REG_MTOP    = 3'd2;
  localparam reg_idx_t REG_MRIGHT  = 3'd3;
  localparam reg_idx_t REG_MBOTTOM = 3'd4;

  typedef struct packed {
    mode_t          mode;
    logic [CW-1:0]  ml;
    logic [CW-1:0]  mt;
    logic [CW-1:0]  mr;
    logic [CW-1:0]  mb;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] l;
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] r;
    logic signed [CW-1:0] b;
    logic signed [MW-1:0] w;
    logic signed [MW-1:0] h;
    logic                 present;
    logic [CW-1:0]        sw;
    logic [CW-1:0]        sh;
    logic                 zero;
    logic                 nw;
    logic                 nh;
  } item_t;

  localparam logic signed [XW-1:0] COORD_MAX = $signed({{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}});
  localparam logic signed [XW-1:0] COORD_MIN = $signed({{(XW-CW+1){1'b1}}, {(CW-1){1'b0}}});

  // halve, rounding toward zero
  function automatic logic signed [XW-1:0] half_trunc(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] s;
    s = x + $signed({{(XW-1){1'b0}}, x[XW-1]});
    return s >>> 1;
  endfunction

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] y;
    y = x;
    if (y > COORD_MAX) y = COORD_MAX;
    if (y < COORD_MIN) y = COORD_MIN;
    return y[CW-1:0];
  endfunction

endpackage

[rtl/image_placement_rect_unit.sv]
// Start to done: s1, s2, s3, divider line, s4, e1, e2, output regs, in every mode.
// Throughput: one word per cycle; busy is low whenever rst is low.
// The depth is set by the two 40-stage bit-per-cycle dividers of the fit path.
// Reset: synchronous, active high; clears pipeline valid bits and all config
// registers (mode 0, margins 0). Results are strobed once, with no backpressure.
`include "assert_macros.svh"

module image_placement_rect_unit import plc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] view_left,
  input  logic signed [CW-1:0] view_top,
  input  logic signed [CW-1:0] view_right,
  input  logic signed [CW-1:0] view_bottom,
  input  logic                 image_present,
  input  logic [CW-1:0]        image_width,
  input  logic [CW-1:0]        image_height,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  reg_idx_t             cfg_index,
  input  logic [CW-1:0]        cfg_data,
  output logic                 done,
  output logic signed [CW-1:0] draw_left,
  output logic signed [CW-1:0] draw_top,
  output logic signed [CW-1:0] draw_right,
  output logic signed [CW-1:0] draw_bottom,
  output logic                 size_fault
);

  cfg_t cfg;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:    cfg.mode <= cfg_data[2:0];
        REG_MLEFT:   cfg.ml   <= cfg_data;
        REG_MTOP:    cfg.mt   <= cfg_data;
        REG_MRIGHT:  cfg.mr   <= cfg_data;
        REG_MBOTTOM: cfg.mb   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // stage 1: extents
  logic  s1_valid;
  item_t s1, s1_next;

  always_comb begin
    s1_next.l       = view_left;
    s1_next.t       = view_top;
    s1_next.r       = view_right;
    s1_next.b       = view_bottom;
    s1_next.w       = $signed({view_right[CW-1], view_right}) -
                      $signed({view_left[CW-1], view_left});
    s1_next.h       = $signed({view_bottom[CW-1], view_bottom}) -
                      $signed({view_top[CW-1], view_top});
    s1_next.present = image_present;
    s1_next.sw      = image_width;
    s1_next.sh      = image_height;
    s1_next.zero    = (image_width == '0) || (image_height == '0);
    s1_next.nw      = s1_next.w[MW-1];
    s1_next.nh      = s1_next.h[MW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1 <= s1_next;
  end

  // stage 2: magnitudes
  logic          s2_valid;
  item_t         s2;
  logic [MW-1:0] mag_w, mag_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2    <= s1;
    mag_w <= s1.w[MW-1] ? MW'(-s1.w) : MW'(s1.w);
    mag_h <= s1.h[MW-1] ? MW'(-s1.h) : MW'(s1.h);
  end

  // stage 3: products
  logic             s3_valid;
  item_t            s3;
  logic [MW+CW-1:0] prod_a, prod_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3     <= s2;
    prod_a <= mag_w * s2.sh;
    prod_b <= mag_h * s2.sw;
  end

  logic [PW-1:0] quo_a, quo_b;

  plc_div u_div_a (
    .clk      (clk),
    .dividend (prod_a[PW-1:0]),
    .divisor  (s3.sw),
    .quotient (quo_a)
  );

  plc_div u_div_b (
    .clk      (clk),
    .dividend (prod_b[PW-1:0]),
    .divisor  (s3.sh),
    .quotient (quo_b)
  );

  // item and valid bit alongside the dividers
  item_t line_it    [DIV_STEPS];
  logic  line_valid [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) line_valid[k] <= 1'b0;
    end else begin
      line_valid[0] <= s3_valid;
      for (int k = 1; k < DIV_STEPS; k++) line_valid[k] <= line_valid[k-1];
    end
    line_it[0] <= s3;
    for (int k = 1; k < DIV_STEPS; k++) line_it[k] <= line_it[k-1];
  end

  // aspect selection
  item_t                d_it;
  logic signed [FW-1:0] qa_s, qb_s, a_v, b_v, w_x, h_x, fw_next, fh_next;

  always_comb begin
    d_it    = line_it[DIV_STEPS-1];
    qa_s    = $signed({2'b00, quo_a});
    qb_s    = $signed({2'b00, quo_b});
    a_v     = d_it.nw ? -qa_s : qa_s;
    b_v     = d_it.nh ? -qb_s : qb_s;
    w_x     = {{(FW-MW){d_it.w[MW-1]}}, d_it.w};
    h_x     = {{(FW-MW){d_it.h[MW-1]}}, d_it.h};
    fw_next = '0;
    fh_next = '0;
    priority if (d_it.zero) begin
      fw_next = '0;
    end else if (d_it.sw > d_it.sh) begin
      if (a_v > h_x) begin
        fw_next = b_v;
        fh_next = h_x;
      end else begin
        fw_next = w_x;
        fh_next = a_v;
      end
    end else begin
      if (b_v > w_x) begin
        fw_next = w_x;
        fh_next = a_v;
      end else begin
        fw_next = b_v;
        fh_next = h_x;
      end
    end
  end

  logic                 s4_valid;
  item_t                s4;
  logic signed [FW-1:0] fw, fh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= line_valid[DIV_STEPS-1];
    end
    s4 <= d_it;
    fw <= fw_next;
    fh <= fh_next;
  end

  plc_place u_place (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s4_valid),
    .it          (s4),
    .fw          (fw),
    .fh          (fh),
    .cfg         (cfg),
    .done        (done),
    .draw_left   (draw_left),
    .draw_top    (draw_top),
    .draw_right  (draw_right),
    .draw_bottom (draw_bottom),
    .size_fault  (size_fault)
  );

  `ASSERT_IMPL(a_latency, start && !busy, ##LATENCY done)
  `ASSERT_IMPL(a_no_stray, done, $past(start && !busy, LATENCY))
  `ASSERT_IMPL(a_fault_strobe, size_fault, done)
  `ASSERT_IMPL(a_fault_mode, size_fault, cfg.mode == MODE_FIT || cfg.mode == MODE_FIT_TOP)

endmodule

[rtl/plc_div.sv]
module plc_div import plc_pkg::*; (
  input  logic          clk,
  input  logic [PW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic [PW-1:0] quotient
);

  // restoring division, one quotient bit per stage
  logic [CW+PW-1:0] acc      [DIV_STEPS];
  logic [CW-1:0]    den      [DIV_STEPS-1];
  logic [CW+PW-1:0] acc_in   [DIV_STEPS];
  logic [CW-1:0]    den_in   [DIV_STEPS];
  logic [CW+PW-1:0] acc_next [DIV_STEPS];
  logic [CW:0]      trial    [DIV_STEPS];
  logic [CW:0]      diff     [DIV_STEPS];

  always_comb begin
    acc_in[0] = {{CW{1'b0}}, dividend};
    den_in[0] = divisor;
    for (int k = 1; k < DIV_STEPS; k++) begin
      acc_in[k] = acc[k-1];
      den_in[k] = den[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k] = acc_in[k][CW+PW-1:PW-1];
      diff[k]  = trial[k] - {1'b0, den_in[k]};
      if (trial[k] >= {1'b0, den_in[k]}) begin
        acc_next[k] = {diff[k][CW-1:0], acc_in[k][PW-2:0], 1'b1};
      end else begin
        acc_next[k] = {trial[k][CW-1:0], acc_in[k][PW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      acc[k] <= acc_next[k];
    end
    for (int k = 0; k < DIV_STEPS - 1; k++) begin
      den[k] <= den_in[k];
    end
  end

  assign quotient = acc[DIV_STEPS-1][PW-1:0];

endmodule

[rtl/plc_place.sv]
module plc_place import plc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  item_t                it,
  input  logic signed [FW-1:0] fw,
  input  logic signed [FW-1:0] fh,
  input  cfg_t                 cfg,
  output logic                 done,
  output logic signed [CW-1:0] draw_left,
  output logic signed [CW-1:0] draw_top,
  output logic signed [CW-1:0] draw_right,
  output logic signed [CW-1:0] draw_bottom,
  output logic                 size_fault
);

  logic signed [XW-1:0] wx, hx, swx, shx, fwx, fhx, cwx, chx;
  logic signed [XW-1:0] offx_next, offy_next, szx_next, szy_next;
  logic                 from_l_next, fault_next;

  logic                 e1_valid;
  item_t                e1_it;
  logic signed [XW-1:0] offx, offy, szx, szy;
  logic                 from_l, e1_fault;

  logic                 e2_valid, e2_fault;
  logic signed [XW-1:0] nl, nt, nr, nb;
  logic signed [XW-1:0] nl_next, nt_next;

  always_comb begin
    wx  = {{(XW-MW){it.w[MW-1]}}, it.w};
    hx  = {{(XW-MW){it.h[MW-1]}}, it.h};
    swx = $signed({{(XW-CW){1'b0}}, it.sw});
    shx = $signed({{(XW-CW){1'b0}}, it.sh});
    fwx = {{(XW-FW){fw[FW-1]}}, fw};
    fhx = {{(XW-FW){fh[FW-1]}}, fh};
    cwx = (wx < swx) ? wx : swx;
    chx = (hx < shx) ? hx : shx;
    offx_next   = '0;
    offy_next   = '0;
    szx_next    = '0;
    szy_next    = '0;
    from_l_next = 1'b0;
    fault_next  = 1'b0;
    priority if (cfg.mode == MODE_MARGIN) begin
      offx_next = $signed({{(XW-CW){1'b0}}, cfg.ml});
      offy_next = $signed({{(XW-CW){1'b0}}, cfg.mt});
      szx_next  = -$signed({{(XW-CW){1'b0}}, cfg.mr});
      szy_next  = -$signed({{(XW-CW){1'b0}}, cfg.mb});
    end else if (it.present && cfg.mode == MODE_CENTER) begin
      offx_next   = half_trunc(wx - cwx);
      offy_next   = half_trunc(hx - chx);
      szx_next    = cwx;
      szy_next    = chx;
      from_l_next = 1'b1;
    end else if (it.present && (cfg.mode == MODE_FIT || cfg.mode == MODE_FIT_TOP)) begin
      offx_next   = half_trunc(wx - fwx);
      offy_next   = (cfg.mode == MODE_FIT) ? half_trunc(hx - fhx) : '0;
      szx_next    = fwx;
      szy_next    = fhx;
      from_l_next = 1'b1;
      fault_next  = it.zero;
    end else begin
      offx_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
    end else begin
      e1_valid <= in_valid;
    end
    e1_it    <= it;
    offx     <= offx_next;
    offy     <= offy_next;
    szx      <= szx_next;
    szy      <= szy_next;
    from_l   <= from_l_next;
    e1_fault <= fault_next;
  end

  always_comb begin
    nl_next = {{(XW-CW){e1_it.l[CW-1]}}, e1_it.l} + offx;
    nt_next = {{(XW-CW){e1_it.t[CW-1]}}, e1_it.t} + offy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_valid <= 1'b0;
    end else begin
      e2_valid <= e1_valid;
    end
    e2_fault <= e1_fault;
    nl <= nl_next;
    nt <= nt_next;
    nr <= (from_l ? nl_next : {{(XW-CW){e1_it.r[CW-1]}}, e1_it.r}) + szx;
    nb <= (from_l ? nt_next : {{(XW-CW){e1_it.b[CW-1]}}, e1_it.b}) + szy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      size_fault <= 1'b0;
    end else begin
      done       <= e2_valid;
      size_fault <= e2_valid & e2_fault;
    end
    draw_left   <= sat_coord(nl);
    draw_top    <= sat_coord(nt);
    draw_right  <= sat_coord(nr);
    draw_bottom <= sat_coord(nb);
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import plc_pkg::*;

  typedef struct {
    logic signed [CW-1:0] vl, vt, vr, vb;
    logic                 present;
    logic [CW-1:0]        sw, sh;
  } view_word_t;

  typedef struct {
    logic signed [CW-1:0] l, t, r, b;
    logic                 fault;
  } placed_t;

  class placement_board;
    placed_t pending[$];
    int      errors;

    task flag(string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
    endtask

    function void note(placed_t e);
      pending.push_back(e);
    endfunction

    task check(placed_t got);
      placed_t e;
      if (pending.size() == 0) begin
        flag("unexpected word on result ports");
        return;
      end
      e = pending.pop_front();
      if (got.l !== e.l) flag($sformatf("draw_left %0d, expected %0d", got.l, e.l));
      if (got.t !== e.t) flag($sformatf("draw_top %0d, expected %0d", got.t, e.t));
      if (got.r !== e.r) flag($sformatf("draw_right %0d, expected %0d", got.r, e.r));
      if (got.b !== e.b) flag($sformatf("draw_bottom %0d, expected %0d", got.b, e.b));
      if (got.fault !== e.fault)
        flag($sformatf("size_fault %0b, expected %0b", got.fault, e.fault));
    endtask
  endclass

  logic                 clk, rst, start, busy;
  logic signed [CW-1:0] view_left, view_top, view_right, view_bottom;
  logic                 image_present;
  logic [CW-1:0]        image_width, image_height;
  logic                 cfg_valid, cfg_ready;
  reg_idx_t             cfg_index;
  logic [CW-1:0]        cfg_data;
  logic                 done;
  logic signed [CW-1:0] draw_left, draw_top, draw_right, draw_bottom;
  logic                 size_fault;

  mode_t         cur_mode;
  logic [CW-1:0] cur_ml, cur_mt, cur_mr, cur_mb;
  int            idle_pct;

  placement_board board = new();

  image_placement_rect_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("image_placement_rect_unit verification failed");
    $finish;
  end

  function automatic longint scale(longint d, longint num, longint den);
    longint q;
    q = ((d < 0) ? -d : d) * num / den;
    if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
    return (d < 0) ? -q : q;
  endfunction

  function automatic logic signed [CW-1:0] clamp_edge(longint x);
    if (x > 524287) x = 524287;
    if (x < -524288) x = -524288;
    return x[CW-1:0];
  endfunction

  function automatic placed_t place_image(view_word_t v);
    longint l, t, r, b, w, h, sw, sh, cw, ch, fw, fh;
    placed_t p;
    l = longint'(v.vl); t = longint'(v.vt);
    r = longint'(v.vr); b = longint'(v.vb);
    sw = longint'({1'b0, v.sw}); sh = longint'({1'b0, v.sh});
    w = r - l; h = b - t;
    p.fault = 1'b0;
    if (cur_mode == MODE_MARGIN) begin
      l += longint'({1'b0, cur_ml}); t += longint'({1'b0, cur_mt});
      r -= longint'({1'b0, cur_mr}); b -= longint'({1'b0, cur_mb});
    end else if (v.present && cur_mode == MODE_CENTER) begin
      cw = (w < sw) ? w : sw;
      ch = (h < sh) ? h : sh;
      l += (w - cw) / 2;
      t += (h - ch) / 2;
      r = l + cw;
      b = t + ch;
    end else if (v.present && (cur_mode == MODE_FIT || cur_mode == MODE_FIT_TOP)) begin
      fw = 0; fh = 0;
      if (sw == 0 || sh == 0) begin
        p.fault = 1'b1;
      end else if (sw > sh) begin
        fw = w; fh = scale(w, sh, sw);
        if (fh > h) begin
          fh = h; fw = scale(h, sw, sh);
        end
      end else begin
        fh = h; fw = scale(h, sw, sh);
        if (fw > w) begin
          fw = w; fh = scale(w, sh, sw);
        end
      end
      l += (w - fw) / 2;
      if (cur_mode == MODE_FIT) t += (h - fh) / 2;
      r = l + fw;
      b = t + fh;
    end
    p.l = clamp_edge(l); p.t = clamp_edge(t);
    p.r = clamp_edge(r); p.b = clamp_edge(b);
    return p;
  endfunction

  always @(negedge clk) begin
    placed_t got;
    if (!rst && done) begin
      got.l = draw_left; got.t = draw_top; got.r = draw_right; got.b = draw_bottom;
      got.fault = size_fault;
      board.check(got);
    end
  end

  // word accepted at the edge where start is high and busy is low
  task send_view(view_word_t v);
    logic free;
    start <= 1'b1;
    view_left <= v.vl; view_top <= v.vt; view_right <= v.vr; view_bottom <= v.vb;
    image_present <= v.present; image_width <= v.sw; image_height <= v.sh;
    do begin
      @(negedge clk);
      free = !busy;
      @(posedge clk);
    end while (!free);
    board.note(place_image(v));
  endtask

  task drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task write_reg(reg_idx_t idx, logic [CW-1:0] val);
    logic rdy;
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:    cur_mode = val[2:0];
      REG_MLEFT:   cur_ml = val;
      REG_MTOP:    cur_mt = val;
      REG_MRIGHT:  cur_mr = val;
      REG_MBOTTOM: cur_mb = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic view_word_t mk(int l, int t, int r, int b, bit p, int w, int h);
    view_word_t v;
    v.vl = CW'(l); v.vt = CW'(t); v.vr = CW'(r); v.vb = CW'(b); v.present = p;
    v.sw = CW'(w); v.sh = CW'(h);
    return v;
  endfunction

  function automatic logic [CW-1:0] rnd_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return CW'($urandom);
      default: return CW'($urandom_range(1, 8000));
    endcase
  endfunction

  function automatic view_word_t rnd_view();
    view_word_t v;
    int x, y;
    if ($urandom_range(0, 3) == 0) begin
      v.vl = CW'($urandom); v.vt = CW'($urandom);
      v.vr = CW'($urandom); v.vb = CW'($urandom);
    end else begin
      x = $urandom_range(0, 20000) - 10000;
      y = $urandom_range(0, 20000) - 10000;
      v.vl = CW'(x); v.vt = CW'(y);
      v.vr = CW'(x + $urandom_range(0, 16000) - 500);
      v.vb = CW'(y + $urandom_range(0, 16000) - 500);
    end
    v.present = ($urandom_range(0, 9) != 0);
    v.sw = rnd_dim();
    v.sh = rnd_dim();
    return v;
  endfunction

  initial begin
    view_word_t dir[$];
    mode_t      dir_mode[$];
    int         n;
    rst = 1'b1; start = 1'b0; cfg_valid = 1'b0; cfg_index = REG_MODE; cfg_data = '0;
    view_left = '0; view_top = '0; view_right = '0; view_bottom = '0;
    image_present = 1'b0; image_width = '0; image_height = '0;
    cur_mode = MODE_CENTER; cur_ml = '0; cur_mt = '0; cur_mr = '0; cur_mb = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir = '{mk(0, 0, 1600, 1200, 1, 800, 600), mk(0, 0, 160, 160, 1, 3200, 80),
            mk(0, 0, 1600, 1200, 0, 800, 600), mk(-5, 7, 100, 90, 1, 4, 4),
            mk(-524288, -524288, 524287, 524287, 1, 1048575, 1048575),
            mk(10, 20, 300, 400, 1, 50, 50), mk(0, 0, 1600, 1200, 1, 1600, 400),
            mk(0, 0, 1600, 1200, 1, 400, 1600), mk(0, 0, 1600, 1200, 1, 0, 600),
            mk(0, 0, 1600, 1200, 1, 800, 0), mk(500, 400, -300, -200, 1, 320, 160),
            mk(0, 0, 1600, 1200, 0, 0, 0),
            mk(-524288, -524288, 524287, 524287, 1, 1048575, 1),
            mk(0, 0, 1600, 1200, 1, 1600, 400), mk(0, 0, 1600, 1200, 1, 400, 1600),
            mk(0, 0, 1600, 1200, 1, 0, 0), mk(1, 2, 3, 4, 1, 5, 6),
            mk(-524288, 524287, 524287, -524288, 1, 7, 9), mk(0, 0, 10, 10, 1, 1, 1)};
    dir_mode = '{MODE_CENTER, MODE_CENTER, MODE_CENTER, MODE_CENTER, MODE_CENTER,
                 MODE_FILL, MODE_FIT, MODE_FIT, MODE_FIT, MODE_FIT, MODE_FIT,
                 MODE_FIT, MODE_FIT, MODE_FIT_TOP, MODE_FIT_TOP, MODE_FIT_TOP,
                 mode_t'(5), mode_t'(6), mode_t'(7)};
    for (int i = 0; i < dir.size(); i++) begin
      if (dir_mode[i] != cur_mode) begin
        drain();
        write_reg(REG_MODE, CW'(dir_mode[i]));
      end
      send_view(dir[i]);
    end
    drain();
    write_reg(REG_MLEFT, 20'd16); write_reg(REG_MTOP, 20'd32);
    write_reg(REG_MRIGHT, 20'd48); write_reg(REG_MBOTTOM, 20'd64);
    write_reg(REG_MODE, CW'(MODE_MARGIN));
    send_view(mk(0, 0, 1600, 1200, 1, 800, 600));
    send_view(mk(-524288, -524288, 524287, 524287, 0, 0, 0));

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      write_reg(REG_MODE, (ph < 8) ? CW'(mode_t'(ph)) : CW'(mode_t'($urandom_range(0, 7))));
      for (int k = 0; k < 4; k++) begin
        reg_idx_t idx;
        logic [CW-1:0] val;
        idx = reg_idx_t'(k + 1);
        val = (ph == 2) ? '1 : (ph == 10) ? '0 :
              ($urandom_range(0, 2) == 0) ? CW'($urandom) : CW'($urandom_range(0, 400));
        write_reg(idx, val);
      end
      case (ph % 4)
        0, 3: idle_pct = 0;
        1:    idle_pct = 72;
        default: idle_pct = 14;
      endcase
      n = 104;
      for (int i = 0; i < n; i++) begin
        if (i == n / 2 && ph == 5) drain();
        if ($urandom_range(1, 100) <= idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        send_view(rnd_view());
      end
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("image_placement_rect_unit verification clean");
    end else begin
      if (board.pending.size() != 0)
        board.flag($sformatf("%0d words never returned", board.pending.size()));
      $display("image_placement_rect_unit verification failed");
    end
    $finish;
  end
endmodule
